[hw/rtl/rgba_to_rgb555_palette_indexer_core_defines.svh]
// Assertion macros shared by the palette indexer RTL.
// Each macro builds one labeled concurrent assertion on clk_i / rst_ni.
`ifndef RGBA_TO_RGB555_PALETTE_INDEXER_CORE_DEFINES_SVH
`define RGBA_TO_RGB555_PALETTE_INDEXER_CORE_DEFINES_SVH

// Checked at every rising edge outside reset.
`define RGBPAL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication form: when trig holds, cons must hold.
`define RGBPAL_ASSERT_IMP(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cons)) \
    else $error(msg);

`endif

[hw/rtl/rgbpal_pkg.sv]
// Shared types and constants for the RGBA to RGB555 palette indexer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rgbpal_pkg;

  localparam int unsigned PAL_DEPTH = 256;
  localparam int unsigned ADDR_W    = $clog2(PAL_DEPTH);
  localparam int unsigned CNT_W     = ADDR_W + 1;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CNT_W-1:0] CAP_SMALL = CNT_W'(16);
  localparam logic [CNT_W-1:0] CAP_LARGE = (PAL_DEPTH < 256) ? CNT_W'(PAL_DEPTH) : CNT_W'(256);

  localparam logic [15:0] STP_BIT = 16'h8000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_USE_ALPHA    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_COLOR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_CUT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STP_CUT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OPAQUE_BLACK = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STP_ON_BLACK = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STP_ON_OTHER = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_MODE  = 3'd7;

  // output modes
  localparam logic [1:0] MODE_DIRECT  = 2'd0;
  localparam logic [1:0] MODE_PAL16   = 2'd1;
  localparam logic [1:0] MODE_PAL256  = 2'd2;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       end_of_image;
  } pix_t;

  typedef struct packed {
    logic [15:0]     color_word;
    logic [7:0]      palette_index;
    logic            new_entry;
    logic            overflow;
    logic [8:0]      entry_count;
    logic            image_done;
  } res_t;

  typedef struct packed {
    logic        use_alpha;
    logic [31:0] key_color;
    logic [7:0]  alpha_cut;
    logic [7:0]  stp_cut;
    logic        opaque_black;
    logic        stp_on_black;
    logic        stp_on_other;
    logic [1:0]  output_mode;
  } cfg_t;

  // one converted pixel waiting for the palette engine
  typedef struct packed {
    logic [15:0] word;
    logic        eoi;
  } qitem_t;

endpackage
`default_nettype wire

[hw/rtl/rgbpal_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module rgbpal_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

[hw/rtl/rgbpal_front.sv]
// Front end: configuration registers and pixel to 16-bit color conversion.
// Depends on rgbpal_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rgbpal_front (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_valid_i,
  input  wire logic [rgbpal_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [31:0]                      cfg_data_i,
  input  wire logic                             accept_i,
  input  wire rgbpal_pkg::pix_t                 pixel_i,
  output logic                                  push_o,
  output rgbpal_pkg::qitem_t                    item_o,
  output rgbpal_pkg::cfg_t                      cfg_o
);
  import rgbpal_pkg::*;

  cfg_t        cfg_q;
  logic [31:0] packed_px;
  logic        is_black;
  logic        stp;
  logic [15:0] word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_USE_ALPHA:    cfg_q.use_alpha    <= cfg_data_i[0];
        REG_KEY_COLOR:    cfg_q.key_color    <= cfg_data_i;
        REG_ALPHA_CUT:    cfg_q.alpha_cut    <= cfg_data_i[7:0];
        REG_STP_CUT:      cfg_q.stp_cut      <= cfg_data_i[7:0];
        REG_OPAQUE_BLACK: cfg_q.opaque_black <= cfg_data_i[0];
        REG_STP_ON_BLACK: cfg_q.stp_on_black <= cfg_data_i[0];
        REG_STP_ON_OTHER: cfg_q.stp_on_other <= cfg_data_i[0];
        REG_OUTPUT_MODE:  cfg_q.output_mode  <= cfg_data_i[1:0];
        default:          cfg_q              <= cfg_q;
      endcase
    end
  end

  always_comb begin
    packed_px = {pixel_i.alpha, pixel_i.blue, pixel_i.green, pixel_i.red};
    is_black  = (pixel_i.red == 8'd0) && (pixel_i.green == 8'd0) &&
                (pixel_i.blue == 8'd0) && (pixel_i.alpha == 8'hFF);
    stp       = cfg_q.use_alpha && (pixel_i.alpha < cfg_q.stp_cut);
    if (is_black) begin
      stp = stp | cfg_q.stp_on_black;
    end else begin
      stp = stp | cfg_q.stp_on_other;
    end
    priority if (!cfg_q.use_alpha && packed_px == cfg_q.key_color) begin
      word = '0;
    end else if (cfg_q.use_alpha && pixel_i.alpha <= cfg_q.alpha_cut) begin
      word = '0;
    end else if (is_black && cfg_q.opaque_black) begin
      word = (cfg_q.stp_on_black ? STP_BIT : 16'h0000) | 16'h0001;
    end else begin
      word = {stp, pixel_i.blue[7:3], pixel_i.green[7:3], pixel_i.red[7:3]};
    end
  end

  assign push_o        = accept_i;
  assign item_o.word   = word;
  assign item_o.eoi    = pixel_i.end_of_image;
  assign cfg_o         = cfg_q;

endmodule
`default_nettype wire

[hw/rtl/rgbpal_queue.sv]
// Two-beat queue between the converter front end and the palette engine.
// Depends on rgbpal_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "rgba_to_rgb555_palette_indexer_core_defines.svh"
module rgbpal_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire rgbpal_pkg::qitem_t item_i,
  input  wire logic               pop_i,
  output rgbpal_pkg::qitem_t      head_o,
  output logic                    full_o,
  output logic                    empty_o
);
  import rgbpal_pkg::*;

  qitem_t     slot_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  assign head_o  = slot_q[rptr_q];
  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);

  `RGBPAL_ASSERT(a_cnt_range, cnt_q != 2'd3, "queue count out of range")
  `RGBPAL_ASSERT_IMP(a_no_push_full, full_o, !push_i, "push into full queue")
  `RGBPAL_ASSERT_IMP(a_no_pop_empty, empty_o, !pop_i, "pop from empty queue")

endmodule
`default_nettype wire

[hw/rtl/rgbpal_back.sv]
// Back end: palette search, append and result formation.
// Depends on rgbpal_pkg, rgbpal_ram and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "rgba_to_rgb555_palette_indexer_core_defines.svh"
module rgbpal_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire rgbpal_pkg::cfg_t   cfg_i,
  input  wire rgbpal_pkg::qitem_t head_i,
  input  wire logic               empty_i,
  output logic                    pop_o,
  output logic                    result_valid_o,
  output rgbpal_pkg::res_t        result_o
);
  import rgbpal_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_RD, ST_CMP, ST_FIN} state_e;

  state_e            state_q;
  logic [ADDR_W-1:0] idx_q;
  logic [CNT_W-1:0]  used_q;
  logic [15:0]       word_q;
  logic              eoi_q;
  logic [1:0]        mode_q;
  logic              rv_q;
  res_t              res_q;

  logic              is_pal;
  logic [CNT_W-1:0]  cap;
  logic              room;
  logic              ram_we, ram_re;
  logic [15:0]       ram_rdata;
  logic [CNT_W-1:0]  next_idx;

  assign is_pal   = (cfg_i.output_mode == MODE_PAL16) || (cfg_i.output_mode == MODE_PAL256);
  assign cap      = (mode_q == MODE_PAL16) ? CAP_SMALL : CAP_LARGE;
  assign room     = used_q < cap;
  assign pop_o    = (state_q == ST_IDLE) && !empty_i;
  assign ram_re   = (state_q == ST_RD);
  assign ram_we   = (state_q == ST_FIN) && room;
  assign next_idx = {1'b0, idx_q} + CNT_W'(1);

  rgbpal_ram #(.WIDTH(16), .DEPTH(PAL_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (used_q[ADDR_W-1:0]),
    .wdata_i (word_q),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      used_q  <= '0;
      word_q  <= '0;
      eoi_q   <= 1'b0;
      mode_q  <= MODE_DIRECT;
      rv_q    <= 1'b0;
      res_q   <= '0;
    end else begin
      rv_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (!empty_i) begin
            word_q <= head_i.word;
            eoi_q  <= head_i.eoi;
            mode_q <= cfg_i.output_mode;
            idx_q  <= '0;
            if (!is_pal) begin
              rv_q  <= 1'b1;
              res_q <= '{color_word: head_i.word, palette_index: 8'd0, new_entry: 1'b0,
                         overflow: 1'b0, entry_count: 9'(used_q),
                         image_done: head_i.eoi};
              if (head_i.eoi) used_q <= '0;
            end else if (used_q != '0) begin
              state_q <= ST_RD;
            end else begin
              state_q <= ST_FIN;
            end
          end
        end
        ST_RD: begin
          state_q <= ST_CMP;
        end
        ST_CMP: begin
          if (ram_rdata == word_q) begin
            rv_q    <= 1'b1;
            res_q   <= '{color_word: word_q, palette_index: 8'(idx_q), new_entry: 1'b0,
                         overflow: 1'b0, entry_count: 9'(used_q), image_done: eoi_q};
            if (eoi_q) used_q <= '0;
            state_q <= ST_IDLE;
          end else if (next_idx == used_q) begin
            state_q <= ST_FIN;
          end else begin
            idx_q   <= next_idx[ADDR_W-1:0];
            state_q <= ST_RD;
          end
        end
        ST_FIN: begin
          rv_q    <= 1'b1;
          state_q <= ST_IDLE;
          if (room) begin
            res_q  <= '{color_word: word_q, palette_index: 8'(used_q), new_entry: 1'b1,
                        overflow: 1'b0, entry_count: 9'(used_q + CNT_W'(1)),
                        image_done: eoi_q};
            used_q <= eoi_q ? '0 : used_q + CNT_W'(1);
          end else begin
            res_q  <= '{color_word: word_q, palette_index: 8'd0, new_entry: 1'b0,
                        overflow: 1'b1, entry_count: 9'(used_q), image_done: eoi_q};
            if (eoi_q) used_q <= '0;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign result_valid_o = rv_q;
  assign result_o       = res_q;

  `RGBPAL_ASSERT(a_used_bound, used_q <= CNT_W'(PAL_DEPTH), "palette count above depth")
  `RGBPAL_ASSERT_IMP(a_cmp_after_rd, state_q == ST_CMP, $past(state_q) == ST_RD,
                     "compare without a read")
  `RGBPAL_ASSERT_IMP(a_fresh_count, rv_q && res_q.new_entry, res_q.entry_count != 9'd0,
                     "new entry with zero count")
  `RGBPAL_ASSERT_IMP(a_flags_excl, rv_q, !(res_q.new_entry && res_q.overflow),
                     "new entry and overflow together")

endmodule
`default_nettype wire

[hw/rtl/rgba_to_rgb555_palette_indexer_core.sv]
// Direct mode: an accepted pixel enters the queue, then the back end registers its result;
// palette mode searches N stored entries serially (one RAM read and compare each).
// Throughput: one beat per cycle in direct mode while busy is low; in palette mode the
// serial RAM search sets the rate, and the queue is not popped until the search ends.
// Results cannot be stalled. Reset (rst_ni low, async) clears registers and palette count.
// Top level: config port, front converter, two-beat queue, palette back end.
`timescale 1ns / 1ps
`default_nettype none
module rgba_to_rgb555_palette_indexer_core (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [rgbpal_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [31:0]                      cfg_data_i,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire rgbpal_pkg::pix_t                 pixel_i,
  output logic                                  result_valid_o,
  output rgbpal_pkg::res_t                      result_o
);
  import rgbpal_pkg::*;

  cfg_t   cfg;
  qitem_t push_item, head;
  logic   push, pop, full, empty;

  assign cfg_ready_o = 1'b1;
  assign busy        = full;

  rgbpal_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (start && !full),
    .pixel_i     (pixel_i),
    .push_o      (push),
    .item_o      (push_item),
    .cfg_o       (cfg)
  );

  rgbpal_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .head_o  (head),
    .full_o  (full),
    .empty_o (empty)
  );

  rgbpal_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .head_i         (head),
    .empty_i        (empty),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule
`default_nettype wire

[dv/rgbpal_scoreboard.sv]
// Checker for the RGBA to RGB555 palette indexer: watches the config, pixel and
// result channels, predicts each result and compares it. Depends on rgbpal_pkg.
`timescale 1ns / 1ps
module rgbpal_scoreboard
  import rgbpal_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  pix_t                 pixel_i,
  input  logic                 result_valid_i,
  input  res_t                 result_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  cfg_t        regs;
  logic [15:0] pal_mem [PAL_DEPTH];
  int unsigned pal_used;
  res_t        expected_q[$];

  assign pending_o = expected_q.size();

  function automatic logic [15:0] to_rgb555(pix_t p);
    logic [31:0] packed_px;
    logic        stp;
    logic        black;
    packed_px = {p.alpha, p.blue, p.green, p.red};
    stp   = 1'b0;
    black = (p.red == 0 && p.green == 0 && p.blue == 0 && p.alpha == 8'hFF);
    if (!regs.use_alpha && packed_px == regs.key_color) return 16'h0;
    if (regs.use_alpha && p.alpha <= regs.alpha_cut) return 16'h0;
    if (regs.use_alpha && p.alpha < regs.stp_cut) stp = 1'b1;
    if (black) begin
      if (regs.opaque_black) return (regs.stp_on_black ? STP_BIT : 16'h0) | 16'h1;
      if (regs.stp_on_black) stp = 1'b1;
    end else if (regs.stp_on_other) begin
      stp = 1'b1;
    end
    return {stp, p.blue[7:3], p.green[7:3], p.red[7:3]};
  endfunction

  function automatic res_t predict_pixel(pix_t p);
    res_t        r;
    int unsigned cap;
    bit          hit;
    r = '0;
    r.color_word = to_rgb555(p);
    if (regs.output_mode == MODE_PAL16 || regs.output_mode == MODE_PAL256) begin
      cap = (regs.output_mode == MODE_PAL16) ? 16 : 256;
      if (cap > PAL_DEPTH) cap = PAL_DEPTH;
      hit = 0;
      for (int i = 0; i < pal_used && i < PAL_DEPTH; i++) begin
        if (!hit && pal_mem[i] == r.color_word) begin
          hit = 1;
          r.palette_index = i[7:0];
        end
      end
      if (!hit) begin
        if (pal_used < cap) begin
          pal_mem[pal_used] = r.color_word;
          r.palette_index   = pal_used[7:0];
          r.new_entry       = 1'b1;
          pal_used++;
        end else begin
          r.overflow = 1'b1;
        end
      end
    end
    r.entry_count = pal_used[8:0];
    r.image_done  = p.end_of_image;
    if (p.end_of_image) pal_used = 0;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t exp_r;
    if (!rst_ni) begin
      regs     <= '0;
      pal_used = 0;
      expected_q.delete();
      fail_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_USE_ALPHA:    regs.use_alpha    <= cfg_data_i[0];
          REG_KEY_COLOR:    regs.key_color    <= cfg_data_i;
          REG_ALPHA_CUT:    regs.alpha_cut    <= cfg_data_i[7:0];
          REG_STP_CUT:      regs.stp_cut      <= cfg_data_i[7:0];
          REG_OPAQUE_BLACK: regs.opaque_black <= cfg_data_i[0];
          REG_STP_ON_BLACK: regs.stp_on_black <= cfg_data_i[0];
          REG_STP_ON_OTHER: regs.stp_on_other <= cfg_data_i[0];
          REG_OUTPUT_MODE:  regs.output_mode  <= cfg_data_i[1:0];
          default: ;
        endcase
      end
      if (start_i && !busy_i) expected_q = {expected_q, predict_pixel(pixel_i)};
      if (result_valid_i) begin
        if (expected_q.size() == 0) begin
          if (fail_count_o < 10) $display("result beat with nothing expected: %p", result_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (result_i !== exp_r) begin
            if (fail_count_o < 10)
              $display("mismatch: exp %p got %p", exp_r, result_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

[dv/tb_rgba_to_rgb555_palette_indexer_core.sv]
// Stimulus top for the RGBA to RGB555 palette indexer: drives config and pixel
// beats, gives the verdict. Depends on rgbpal_pkg, the core and rgbpal_scoreboard.
`timescale 1ns / 1ps
module tb_rgba_to_rgb555_palette_indexer_core;
  import rgbpal_pkg::*;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;
  logic                 start = 1'b0;
  logic                 busy;
  pix_t                 pixel = '0;
  logic                 result_valid;
  res_t                 result;
  int                   fail_count;
  int                   pending;
  logic [31:0]          cur_key;

  rgba_to_rgb555_palette_indexer_core i_dut (
    .clk_i, .rst_ni,
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .start, .busy,
    .pixel_i(pixel),
    .result_valid_o(result_valid), .result_o(result)
  );

  rgbpal_scoreboard i_scoreboard (
    .clk_i, .rst_ni,
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .start_i(start), .busy_i(busy), .pixel_i(pixel),
    .result_valid_i(result_valid), .result_i(result),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial forever #1 clk_i = ~clk_i;

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // drain, then idle past the longest palette search
  task automatic wait_idle();
    while (pending != 0 || busy) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) n = 0;
    repeat (n) @(posedge clk_i);
  endtask

  // one pixel beat; start is held across back-to-back beats
  task automatic send_pixel(pix_t p, bit gaps);
    start <= 1'b1;
    pixel <= p;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (gaps && $urandom_range(0, 2) != 0) begin
      start <= 1'b0;
      idle_gap();
    end
  endtask

  function automatic pix_t mk(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                              logic [7:0] a, logic eoi);
    pix_t p;
    p.red = r; p.green = g; p.blue = b; p.alpha = a; p.end_of_image = eoi;
    return p;
  endfunction

  // mostly colors drawn from a small set so the palette gets hits
  function automatic pix_t rand_pixel(int n_colors, bit eoi);
    pix_t p;
    int   c;
    p = pix_t'({$urandom, 1'b0});
    case ($urandom_range(0, 9))
      0: p = mk(0, 0, 0, 8'hFF, 0);
      1: p = mk(cur_key[7:0], cur_key[15:8], cur_key[23:16], cur_key[31:24], 0);
      2, 3: ;
      default: begin
        c = $urandom_range(0, n_colors - 1);
        p.red = 8'(c * 8); p.green = 8'((c * 37) & 8'hF8); p.blue = 8'((c * 91) & 8'hF8);
        p.red[2:0] = 3'($urandom); p.alpha[7] = 1'b1;
      end
    endcase
    p.end_of_image = eoi;
    return p;
  endfunction

  initial begin
    pix_t p;
    int   len;
    int   sent;
    int   n_colors;
    sent = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings, direct mode; key 0 matches all-zero pixel
    cur_key = 32'h0;
    send_pixel(mk(0, 0, 0, 0, 0), 0);
    send_pixel(mk(8'hFF, 8'hFF, 8'hFF, 8'hFF, 0), 0);
    send_pixel(mk(0, 0, 0, 8'hFF, 0), 0);
    send_pixel(mk(8'h07, 8'hF8, 8'h80, 8'h01, 1), 0);
    start <= 1'b0;
    wait_idle();

    cur_key = 32'h80FF0010;
    write_reg(REG_KEY_COLOR, cur_key);
    write_reg(REG_OPAQUE_BLACK, 1);
    write_reg(REG_STP_ON_BLACK, 1);
    write_reg(REG_STP_ON_OTHER, 1);
    write_reg(REG_OUTPUT_MODE, MODE_PAL16);
    send_pixel(mk(8'h10, 8'h00, 8'hFF, 8'h80, 0), 0);
    send_pixel(mk(0, 0, 0, 8'hFF, 0), 0);
    send_pixel(mk(0, 0, 0, 8'hFF, 0), 0);
    for (int i = 0; i < 17; i++) send_pixel(mk(i * 8, 0, 0, 8'hFF, i == 16), 0);
    start <= 1'b0;
    wait_idle();

    write_reg(REG_USE_ALPHA, 1);
    write_reg(REG_ALPHA_CUT, 8'h40);
    write_reg(REG_STP_CUT, 8'hFF);
    write_reg(REG_OUTPUT_MODE, 3);
    send_pixel(mk(1, 2, 3, 8'h40, 0), 0);
    send_pixel(mk(1, 2, 3, 8'h41, 0), 0);
    send_pixel(mk(1, 2, 3, 8'hFF, 1), 0);
    start <= 1'b0;
    wait_idle();

    // random phases: new settings, then a few images each
    while (sent < 1900) begin
      write_reg(REG_USE_ALPHA, $urandom_range(0, 1));
      cur_key = $urandom;
      write_reg(REG_KEY_COLOR, ($urandom_range(0, 1)) ? cur_key : 32'hFF000000);
      if (!$urandom_range(0, 1)) cur_key = 32'hFF000000;
      write_reg(REG_ALPHA_CUT, ($urandom_range(0, 3) == 0) ? 8'hFF : $urandom_range(0, 255));
      write_reg(REG_STP_CUT, ($urandom_range(0, 3) == 0) ? 8'h00 : $urandom_range(0, 255));
      write_reg(REG_OPAQUE_BLACK, $urandom_range(0, 1));
      write_reg(REG_STP_ON_BLACK, $urandom_range(0, 1));
      write_reg(REG_STP_ON_OTHER, $urandom_range(0, 1));
      write_reg(REG_OUTPUT_MODE, $urandom_range(0, 3));
      n_colors = ($urandom_range(0, 4) == 0) ? 300 : $urandom_range(2, 24);
      for (int img = 0; img < 3; img++) begin
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(150, 300) : $urandom_range(1, 60);
        if (len > 1900 - sent) len = 1900 - sent;
        for (int k = 0; k < len; k++) begin
          // occasional mid-image mode change after a full drain
          if (k == len / 2 && $urandom_range(0, 7) == 0) begin
            start <= 1'b0;
            wait_idle();
            write_reg(REG_OUTPUT_MODE, $urandom_range(0, 2));
          end
          p = rand_pixel(n_colors, k == len - 1);
          send_pixel(p, $urandom_range(0, 3) != 0);
          sent++;
        end
      end
      start <= 1'b0;
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
